/* design/last_note_priority_key_assigner_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the last-note priority key assigner
// Concurrent property wrappers, clocked on i_clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef LAST_NOTE_PRIORITY_KEY_ASSIGNER_ASSERT_SVH
`define LAST_NOTE_PRIORITY_KEY_ASSIGNER_ASSERT_SVH

`ifndef SYNTHESIS

`define LNPKA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key assigner check failed");

`define LNPKA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key assigner check failed");

`else

`define LNPKA_ASSERT_SAME(lbl, ante, cons)

`define LNPKA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/lnpka_pkg.sv */
// ---------------------------------------------------------------------------
// lnpka_pkg
// Shared types and constants of the last-note priority key assigner.
// ---------------------------------------------------------------------------
`default_nettype none

package lnpka_pkg;

    typedef enum logic [2:0] {
        OP_NOTE_ON  = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_ALL_OFF  = 3'd2,
        OP_WHEEL    = 3'd3,
        OP_CTRL     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ENV_NONE       = 2'd0,
        ENV_TRIGGER    = 2'd1,
        ENV_RELEASE    = 2'd2,
        ENV_HARD_RESET = 2'd3
    } t_env;

    typedef enum logic [1:0] {
        STK_PUSH  = 2'd0,
        STK_POP   = 2'd1,
        STK_CLEAR = 2'd2
    } t_stk_op;

    typedef enum logic {
        STK_IDLE = 1'b0,
        STK_SCAN = 1'b1
    } t_stk_state;

    typedef struct packed {
        logic       valid;
        t_stk_op    op;
        logic [6:0] note;
    } t_stk_cmd;

    typedef struct packed {
        logic       done;
        t_env       env;
        logic       from_silence;
        logic       busy;
        logic       any_held;
        logic [6:0] target;
    } t_stk_rsp;

    localparam logic                CFG_GLIDE      = 1'b0;
    localparam logic                CFG_BEND_RANGE = 1'b1;
    localparam logic [6:0]          MOD_WHEEL_CC   = 7'd1;
    localparam logic signed [14:0]  WHEEL_CENTRE   = 15'sd8192;
    localparam logic [4:0]          BEND_RANGE_MAX = 5'd24;
    localparam logic [4:0]          BEND_RANGE_RST = 5'd2;

endpackage

`default_nettype wire

/* design/lnpka_ram.sv */
// ---------------------------------------------------------------------------
// lnpka_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module lnpka_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/lnpka_stack.sv */
// ---------------------------------------------------------------------------
// lnpka_stack
// Held-note stack kept as a ring in a RAM, with a compacting note-off scan.
// ---------------------------------------------------------------------------
`default_nettype none

module lnpka_stack #(
    parameter int DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lnpka_pkg::t_stk_cmd i_cmd,
    output lnpka_pkg::t_stk_rsp      o_rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Logical stack position to RAM address, oldest entry at r_base.
    function automatic logic [PW-1:0] f_phys(input logic [PW-1:0] base,
                                             input logic [CW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(idx);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    lnpka_pkg::t_stk_state r_state, n_state;
    logic [PW-1:0] r_base, n_base;
    logic [CW-1:0] r_count, n_count;
    logic [6:0]    r_target, n_target;
    logic [CW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_wr, n_wr;
    logic          r_rd_vld, n_rd_vld;
    logic [6:0]    r_kept, n_kept;
    logic [6:0]    r_note, n_note;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [6:0]    ram_wdata;
    logic          ram_re;
    logic [PW-1:0] ram_raddr;
    logic [6:0]    ram_rdata;

    logic          issue;
    logic          scan_end;
    logic          full;

    assign issue    = (r_state == lnpka_pkg::STK_SCAN) && (r_rd != r_count);
    assign scan_end = (r_rd == r_count) && !r_rd_vld;
    assign full     = (r_count == CW'(DEPTH));

    lnpka_ram #(
        .WIDTH (7),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lnpka_pkg::STK_IDLE: begin
                if (i_cmd.valid && (i_cmd.op == lnpka_pkg::STK_POP)) begin
                    n_state = lnpka_pkg::STK_SCAN;
                end
            end
            lnpka_pkg::STK_SCAN: begin
                if (scan_end) begin
                    n_state = lnpka_pkg::STK_IDLE;
                end
            end
            default: n_state = lnpka_pkg::STK_IDLE;
        endcase
    end

    always_comb begin
        n_base   = r_base;
        n_count  = r_count;
        n_target = r_target;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_rd_vld = r_rd_vld;
        n_kept   = r_kept;
        n_note   = r_note;

        ram_we    = 1'b0;
        ram_waddr = f_phys(r_base, r_wr);
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = f_phys(r_base, r_rd);

        o_rsp.done         = 1'b0;
        o_rsp.env          = lnpka_pkg::ENV_NONE;
        o_rsp.from_silence = 1'b0;
        o_rsp.busy         = (r_state == lnpka_pkg::STK_SCAN);
        o_rsp.any_held     = (r_count != '0);
        o_rsp.target       = r_target;

        unique case (r_state)
            lnpka_pkg::STK_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.op)
                        lnpka_pkg::STK_PUSH: begin
                            // A full stack drops its oldest entry: the new note
                            // takes the old base slot and the base moves on.
                            ram_we    = 1'b1;
                            ram_wdata = i_cmd.note;
                            if (full) begin
                                ram_waddr = r_base;
                                n_base    = (r_base == PW'(DEPTH - 1)) ? '0
                                                                        : r_base + 1'b1;
                            end else begin
                                ram_waddr = f_phys(r_base, r_count);
                                n_count   = r_count + 1'b1;
                            end
                            n_target           = i_cmd.note;
                            o_rsp.done         = 1'b1;
                            o_rsp.from_silence = (r_count == '0);
                            o_rsp.env          = (r_count == '0) ? lnpka_pkg::ENV_TRIGGER
                                                                 : lnpka_pkg::ENV_NONE;
                        end
                        lnpka_pkg::STK_POP: begin
                            n_note   = i_cmd.note;
                            n_rd     = '0;
                            n_wr     = '0;
                            n_rd_vld = 1'b0;
                        end
                        lnpka_pkg::STK_CLEAR: begin
                            n_count    = '0;
                            o_rsp.done = 1'b1;
                            o_rsp.env  = lnpka_pkg::ENV_HARD_RESET;
                        end
                        default: ;
                    endcase
                end
            end
            lnpka_pkg::STK_SCAN: begin
                // Reads run at least one entry ahead of the writes, so a write never
                // lands on an entry that still has to be read.
                ram_re   = issue;
                n_rd_vld = issue;
                if (issue) begin
                    n_rd = r_rd + 1'b1;
                end
                if (r_rd_vld && (ram_rdata != r_note)) begin
                    ram_we = 1'b1;
                    n_wr   = r_wr + 1'b1;
                    n_kept = ram_rdata;
                end
                if (scan_end) begin
                    n_count    = r_wr;
                    o_rsp.done = 1'b1;
                    if (r_wr != '0) begin
                        n_target = r_kept;
                    end else begin
                        o_rsp.env = lnpka_pkg::ENV_RELEASE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lnpka_pkg::STK_IDLE;
            r_base   <= '0;
            r_count  <= '0;
            r_target <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_count  <= n_count;
            r_target <= n_target;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kept <= n_kept;
        r_note <= n_note;
    end

endmodule

`default_nettype wire

/* design/last_note_priority_key_assigner.sv */
// ---------------------------------------------------------------------------
// last_note_priority_key_assigner
// Monophonic key assigner with last-note priority and pitch wheel scaling.
// ---------------------------------------------------------------------------
// Each accepted item gives exactly one result, shown for one cycle with
// o_valid high; the receiver cannot stall, so it must take every result as it
// appears. For note-on, all-notes-off, pitch wheel, controller and unused op
// codes the result appears in the cycle after acceptance and a new item may be
// started at once. A note-off (or a note-on with zero velocity) scans the
// held-note stack memory one entry per cycle and keeps busy high until the scan
// ends; its result appears as busy falls.
`default_nettype none

`include "last_note_priority_key_assigner_assert.svh"

module last_note_priority_key_assigner #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_op,
    input  wire logic [6:0]         i_note,
    input  wire logic [6:0]         i_velocity,
    input  wire logic [13:0]        i_wheel_value,
    input  wire logic [6:0]         i_controller_number,
    input  wire logic [6:0]         i_controller_value,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [4:0]         i_cfg_data,
    output logic                    o_valid,
    output logic [6:0]              o_target_note,
    output logic                    o_any_held,
    output logic [1:0]              o_env_action,
    output logic                    o_glide_snap,
    output logic [6:0]              o_note_velocity,
    output logic signed [18:0]      o_bend_amount,
    output logic [6:0]              o_mod_wheel
);

    logic                r_glide, n_glide;
    logic [4:0]          r_bend_range, n_bend_range;
    logic [6:0]          r_velocity, n_velocity;
    logic signed [18:0]  r_bend, n_bend;
    logic [6:0]          r_mod, n_mod;
    logic                r_valid, n_valid;
    lnpka_pkg::t_env     r_env, n_env;
    logic                r_snap, n_snap;

    logic                accept;
    lnpka_pkg::t_stk_cmd stk_cmd;
    lnpka_pkg::t_stk_rsp stk_rsp;
    logic [4:0]          range_sat;
    logic signed [14:0]  wheel_off;
    logic signed [20:0]  bend_prod;

    assign accept = start && !busy;
    assign busy   = stk_rsp.busy;

    assign range_sat = (r_bend_range > lnpka_pkg::BEND_RANGE_MAX) ? lnpka_pkg::BEND_RANGE_MAX
                                                                   : r_bend_range;
    assign wheel_off = $signed({1'b0, i_wheel_value}) - lnpka_pkg::WHEEL_CENTRE;
    assign bend_prod = wheel_off * $signed({1'b0, range_sat});

    // Op decode: note events and all-notes-off go to the stack, the rest finish here.
    always_comb begin
        stk_cmd.valid = 1'b0;
        stk_cmd.op    = lnpka_pkg::STK_PUSH;
        stk_cmd.note  = i_note;
        unique case (lnpka_pkg::t_op'(i_op))
            lnpka_pkg::OP_NOTE_ON: begin
                stk_cmd.valid = accept;
                stk_cmd.op    = (i_velocity != '0) ? lnpka_pkg::STK_PUSH
                                                    : lnpka_pkg::STK_POP;
            end
            lnpka_pkg::OP_NOTE_OFF: begin
                stk_cmd.valid = accept;
                stk_cmd.op    = lnpka_pkg::STK_POP;
            end
            lnpka_pkg::OP_ALL_OFF: begin
                stk_cmd.valid = accept;
                stk_cmd.op    = lnpka_pkg::STK_CLEAR;
            end
            default: ;
        endcase
    end

    lnpka_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_rsp   (stk_rsp)
    );

    always_comb begin
        n_glide      = r_glide;
        n_bend_range = r_bend_range;
        n_velocity   = r_velocity;
        n_bend       = r_bend;
        n_mod        = r_mod;
        n_valid      = (accept && !stk_cmd.valid) || stk_rsp.done;
        n_env        = stk_rsp.done ? stk_rsp.env : lnpka_pkg::ENV_NONE;
        n_snap       = stk_rsp.done && stk_rsp.from_silence && !r_glide;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lnpka_pkg::CFG_GLIDE:      n_glide      = i_cfg_data[0];
                lnpka_pkg::CFG_BEND_RANGE: n_bend_range = i_cfg_data;
                default: ;
            endcase
        end

        if (accept) begin
            unique case (lnpka_pkg::t_op'(i_op))
                lnpka_pkg::OP_NOTE_ON: begin
                    if (i_velocity != '0) begin
                        n_velocity = i_velocity;
                    end
                end
                lnpka_pkg::OP_WHEEL: begin
                    n_bend = bend_prod[18:0];
                end
                lnpka_pkg::OP_CTRL: begin
                    if (i_controller_number == lnpka_pkg::MOD_WHEEL_CC) begin
                        n_mod = i_controller_value;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glide      <= 1'b0;
            r_bend_range <= lnpka_pkg::BEND_RANGE_RST;
            r_velocity   <= '0;
            r_bend       <= '0;
            r_mod        <= '0;
            r_valid      <= 1'b0;
            r_env        <= lnpka_pkg::ENV_NONE;
            r_snap       <= 1'b0;
        end else begin
            r_glide      <= n_glide;
            r_bend_range <= n_bend_range;
            r_velocity   <= n_velocity;
            r_bend       <= n_bend;
            r_mod        <= n_mod;
            r_valid      <= n_valid;
            r_env        <= n_env;
            r_snap       <= n_snap;
        end
    end

    assign o_valid         = r_valid;
    assign o_target_note   = stk_rsp.target;
    assign o_any_held      = stk_rsp.any_held;
    assign o_env_action    = r_env;
    assign o_glide_snap    = r_snap;
    assign o_note_velocity = r_velocity;
    assign o_bend_amount   = r_bend;
    assign o_mod_wheel     = r_mod;

    `LNPKA_ASSERT_SAME(a_no_result_while_busy, o_valid, !busy)
    `LNPKA_ASSERT_NEXT(a_accept_progresses, start && !busy, o_valid || busy)
    `LNPKA_ASSERT_SAME(a_release_means_empty,
        o_valid && (o_env_action == lnpka_pkg::ENV_RELEASE), !o_any_held)
    `LNPKA_ASSERT_SAME(a_trigger_means_held,
        o_valid && (o_env_action == lnpka_pkg::ENV_TRIGGER), o_any_held)

endmodule

`default_nettype wire
